### design/lpgrb_pkg.sv
// Package: payload types, constants and tables for the lidar point grid and range binning core.
package lpgrb_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ANG_W = 25;
   localparam int CW = 28;
   localparam logic [16:0] NO_READING = 17'h1FFFF;

   typedef enum logic [1:0] {
      CSR_PPM    = 2'd0,
      CSR_HALF   = 2'd1,
      CSR_WIDTH  = 2'd2,
      CSR_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_COL,
      ST_MUL_ROW,
      ST_CHECK,
      ST_SQ_X,
      ST_SQ_Y,
      ST_CORDIC,
      ST_SQRT,
      ST_WRITE,
      ST_READ,
      ST_READ_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        opcode;
      logic [15:0] point_x;
      logic [15:0] point_y;
      logic [8:0]  bin_select;
   } req_type;

   typedef struct packed {
      logic        in_image;
      logic [9:0]  pixel_col;
      logic [9:0]  pixel_row;
      logic [8:0]  bin_index;
      logic        bin_written;
      logic [16:0] range_value;
   } rsp_type;

   function automatic logic [ANG_W-1:0] atan_deg(input logic [3:0] i);
      case (i)
         4'd0:    atan_deg = 25'd2949120;
         4'd1:    atan_deg = 25'd1740967;
         4'd2:    atan_deg = 25'd919879;
         4'd3:    atan_deg = 25'd466945;
         4'd4:    atan_deg = 25'd234379;
         4'd5:    atan_deg = 25'd117304;
         4'd6:    atan_deg = 25'd58666;
         4'd7:    atan_deg = 25'd29335;
         4'd8:    atan_deg = 25'd14668;
         4'd9:    atan_deg = 25'd7334;
         4'd10:   atan_deg = 25'd3667;
         4'd11:   atan_deg = 25'd1833;
         4'd12:   atan_deg = 25'd917;
         4'd13:   atan_deg = 25'd458;
         4'd14:   atan_deg = 25'd229;
         default: atan_deg = 25'd115;
      endcase
   endfunction

endpackage

### design/lpgrb_cordic.sv
// Iterative CORDIC vectoring unit: whole-degree bearing for y > 0, one step per cycle.
module lpgrb_cordic
   import lpgrb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] x,
   input  logic signed [15:0] y,
   output logic               done,
   output logic [7:0]         degrees
);

   logic signed [CW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ANG_W:0]   z_ff, z_in;
   logic [3:0]              step_ff, step_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic signed [CW-1:0]    dx, dy, xs, ys;
   logic signed [ANG_W:0]   dz;
   logic signed [ANG_W:0]   zq;

   assign xs = CW'(x) <<< 8;
   assign ys = CW'(y) <<< 8;
   assign dx = cy_ff >>> step_ff;
   assign dy = cx_ff >>> step_ff;
   assign dz = $signed({1'b0, atan_deg(step_ff)});

   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         step_in = '0;
         busy_in = 1'b1;
         if (x < 0) begin
            cx_in = ys;
            cy_in = -xs;
            z_in  = (ANG_W+1)'(90 * 65536);
         end else begin
            cx_in = xs;
            cy_in = ys;
            z_in  = '0;
         end
      end else if (busy_ff) begin
         if (cy_ff > 0) begin
            cx_in = cx_ff + dx;
            cy_in = cy_ff - dy;
            z_in  = z_ff + dz;
         end else begin
            cx_in = cx_ff - dx;
            cy_in = cy_ff + dy;
            z_in  = z_ff - dz;
         end
         step_in = step_ff + 4'd1;
         if (step_ff == 4'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign zq   = z_ff >>> 16;
   assign done = done_ff;

   always_comb begin
      if (z_ff < 0)
         degrees = 8'd0;
      else if (zq > 179)
         degrees = 8'd179;
      else
         degrees = zq[7:0];
   end

endmodule

### design/lidar_point_grid_and_range_binning_core.sv
// Top level: point to pixel mapping, bearing and range binning with a per-degree range table.
//
// Requests enter on req_valid/req_ready and carry a req_type payload. A point
// request (opcode 0) is mapped to a pixel with the shared multiplier, then the
// bearing is found by a 16-step CORDIC and the distance by a bit-serial square
// root (16 steps); the distance goes to the range table. A read request
// (opcode 1) returns one table entry.
// A read passes ST_READ, ST_READ_WAIT and ST_OUT. A point outside the image or
// below the x axis goes to ST_OUT after the check; a point on the x axis skips
// the CORDIC; a point with y > 0 passes 2 multiplies, a check, 2 squares, CORDIC
// start and 16 steps, 16 root steps plus a finish step, the table write and output.
// The block takes one request at a time and is not ready while busy; the next
// request is not taken while rsp_valid is high.
// The result stays in an output register on rsp_valid/rsp_data until rsp_ready;
// a stalled receiver holds the block. The csr_ port writes the four registers
// and is always ready.
// After reset a clearing pass writes all-ones to every table entry, one per
// cycle, and req_ready stays low until it ends.
module lidar_point_grid_and_range_binning_core
   import lpgrb_pkg::*;
#(
   parameter int NUM_BINS = 270,
   parameter int MAX_IMAGE_DIM = 1024
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata
);

   localparam int BIN_W = $clog2(NUM_BINS);
   localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);

   logic [9:0]  ppm_ff;
   logic [14:0] half_ff;
   logic [10:0] width_ff, height_ff;

   state_type   state_ff, state_in;
   req_type     req_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff;
   logic signed [27:0] col_ff, row_ff, prod_in;
   logic [31:0] sq_ff, sq_in;
   logic [31:0] rem_ff, rem_in, root_ff, root_in, rbit_ff, rbit_in;
   logic [BIN_W-1:0] clr_ff;
   logic        clearing_ff;
   logic [8:0]  deg_ff;

   logic [16:0] table_mem [NUM_BINS];
   logic [16:0] rd_ff;
   logic        wr_en;
   logic [BIN_W-1:0] wr_addr;
   logic [16:0] wr_data;

   logic        cordic_start, cordic_done;
   logic [7:0]  cordic_deg;

   logic signed [16:0] mul_a;
   logic signed [16:0] diff_col, diff_row;
   logic signed [15:0] px, py;
   logic [DIM_W-1:0]   w_sat, h_sat;
   logic               pix_ok;
   logic [31:0]        trial;

   assign px = $signed(req_ff.point_x);
   assign py = $signed(req_ff.point_y);
   assign diff_col = $signed({2'b0, half_ff}) - 17'(py);
   assign diff_row = $signed({2'b0, half_ff}) - 17'(px);

   assign w_sat = (32'(width_ff) > 32'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM)
                                                       : DIM_W'(width_ff);
   assign h_sat = (32'(height_ff) > 32'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM)
                                                        : DIM_W'(height_ff);

   // col_ff/row_ff hold the quotient, truncated toward zero
   assign pix_ok = !col_ff[27] && !row_ff[27]
                   && (col_ff < $signed(28'(w_sat))) && (row_ff < $signed(28'(h_sat)));

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE) && !clearing_ff && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ppm_ff    <= 10'd250;
         half_ff   <= 15'd8192;
         width_ff  <= 11'd1000;
         height_ff <= 11'd1000;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PPM:    ppm_ff    <= csr_wdata[9:0];
            CSR_HALF:   half_ff   <= csr_wdata;
            CSR_WIDTH:  width_ff  <= csr_wdata[10:0];
            CSR_HEIGHT: height_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   lpgrb_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .x       (px),
      .y       (py),
      .done    (cordic_done),
      .degrees (cordic_deg)
   );

   // shared multiplier: ppm * diff, or a square
   logic signed [33:0] mprod;
   logic signed [33:0] mtrunc;
   always_comb begin
      mul_a = diff_col;
      case (state_ff)
         ST_MUL_COL: mul_a = diff_col;
         ST_MUL_ROW: mul_a = diff_row;
         ST_SQ_X:    mul_a = 17'(px);
         ST_SQ_Y:    mul_a = 17'(py);
         default:    mul_a = diff_col;
      endcase
      if (state_ff == ST_SQ_X || state_ff == ST_SQ_Y)
         mprod = 34'(mul_a) * 34'(mul_a);
      else
         mprod = 34'(mul_a) * $signed({24'b0, ppm_ff});
      mtrunc  = (mprod < 0) ? -((-mprod) >>> 12) : (mprod >>> 12);
      prod_in = mtrunc[27:0];
   end

   assign trial = root_ff + rbit_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_in       = rsp_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      rbit_in      = rbit_ff;
      cordic_start = 1'b0;
      case (state_ff)
         ST_IDLE:
            if (req_valid && req_ready)
               state_in = req_data.opcode ? ST_READ : ST_MUL_COL;
         ST_MUL_COL: state_in = ST_MUL_ROW;
         ST_MUL_ROW: state_in = ST_CHECK;
         ST_CHECK: begin
            rsp_in = '{default: '0};
            rsp_in.range_value = NO_READING;
            if (pix_ok) begin
               rsp_in.in_image  = 1'b1;
               rsp_in.pixel_col = col_ff[9:0];
               rsp_in.pixel_row = row_ff[9:0];
            end
            if (pix_ok && !py[15])
               state_in = ST_SQ_X;
            else
               state_in = ST_OUT;
         end
         ST_SQ_X: begin
            sq_in    = mprod[31:0];
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            rem_in  = sq_ff + mprod[31:0];
            root_in = '0;
            rbit_in = 32'h4000_0000;
            if (py != 16'sd0) begin
               cordic_start = 1'b1;
               state_in     = ST_CORDIC;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_CORDIC:
            if (cordic_done)
               state_in = ST_SQRT;
         ST_SQRT: begin
            if (rbit_ff == '0) begin
               state_in = ST_WRITE;
            end else begin
               if (rem_ff >= trial) begin
                  rem_in  = rem_ff - trial;
                  root_in = (root_ff >> 1) + rbit_ff;
               end else begin
                  root_in = root_ff >> 1;
               end
               rbit_in = rbit_ff >> 2;
            end
         end
         ST_WRITE: begin
            if (32'(deg_ff) < 32'(NUM_BINS)) begin
               rsp_in.bin_index   = deg_ff;
               rsp_in.bin_written = 1'b1;
               rsp_in.range_value = root_ff[16:0];
            end
            state_in = ST_OUT;
         end
         ST_READ: state_in = ST_READ_WAIT;
         ST_READ_WAIT: begin
            rsp_in = '{default: '0};
            rsp_in.bin_index = req_ff.bin_select;
            rsp_in.range_value = (32'(req_ff.bin_select) < 32'(NUM_BINS)) ? rd_ff : NO_READING;
            state_in = ST_OUT;
         end
         ST_OUT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = NO_READING;
      if (clearing_ff) begin
         wr_en = 1'b1;
      end else if (state_ff == ST_WRITE && 32'(deg_ff) < 32'(NUM_BINS)) begin
         wr_en   = 1'b1;
         wr_addr = deg_ff[BIN_W-1:0];
         wr_data = root_ff[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         table_mem[wr_addr] <= wr_data;
      rd_ff <= table_mem[req_ff.bin_select[BIN_W-1:0]];
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rbit_ff <= rbit_in;
      if (state_ff == ST_IDLE && req_valid && req_ready)
         req_ff <= req_data;
      if (state_ff == ST_MUL_COL)
         col_ff <= prod_in;
      if (state_ff == ST_MUL_ROW)
         row_ff <= prod_in;
      if (state_ff == ST_SQ_Y)
         deg_ff <= (py == 16'sd0) ? (px[15] ? 9'd180 : 9'd0) : 9'd0;
      else if (cordic_done)
         deg_ff <= {1'b0, cordic_deg};
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
         if (clearing_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == BIN_W'(NUM_BINS - 1))
               clearing_ff <= 1'b0;
         end
      end
   end

endmodule

### verif/lpgrb_checker.sv
// Checker: watches the request, response and register channels, predicts each response and compares.
module lpgrb_checker
   import lpgrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_wdata,
   output int          error_count,
   output int          pending_count
);

   localparam int NUM_BINS = 270;
   localparam int MAX_DIM = 1024;

   logic [9:0]  scale_ppm;
   logic [14:0] half_ext;
   logic [10:0] img_w;
   logic [10:0] img_h;
   logic [16:0] range_bins [NUM_BINS];
   rsp_type     expected_rsp [$];

   function automatic logic [16:0] int_sqrt(input longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root[16:0];
   endfunction

   function automatic int bearing_deg(input longint px, input longint py);
      longint cx, cy, z, dx, dy;
      longint atan_tab [16];
      atan_tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115};
      px = px * 256;
      py = py * 256;
      z = 0;
      if (px < 0) begin
         cx = py;
         cy = -px;
         z = 90 * 65536;
      end else begin
         cx = px;
         cy = py;
      end
      for (int i = 0; i < 16; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy > 0) begin
            cx += dx;
            cy -= dy;
            z += atan_tab[i];
         end else begin
            cx -= dx;
            cy += dy;
            z -= atan_tab[i];
         end
      end
      if (z < 0) return 0;
      z = z >>> 16;
      return (z > 179) ? 179 : int'(z);
   endfunction

   function automatic rsp_type bin_point(input req_type rq);
      rsp_type r;
      longint x, y, col, row, w, h;
      int deg;
      r = '0;
      r.range_value = NO_READING;
      if (rq.opcode) begin
         r.bin_index = rq.bin_select;
         if (rq.bin_select < NUM_BINS) r.range_value = range_bins[rq.bin_select];
         return r;
      end
      x = longint'($signed(rq.point_x));
      y = longint'($signed(rq.point_y));
      col = (longint'(scale_ppm) * (longint'(half_ext) - y)) / 4096;
      row = (longint'(scale_ppm) * (longint'(half_ext) - x)) / 4096;
      w = (img_w > MAX_DIM) ? MAX_DIM : img_w;
      h = (img_h > MAX_DIM) ? MAX_DIM : img_h;
      if (col >= 0 && col < w && row >= 0 && row < h) begin
         r.in_image = 1'b1;
         r.pixel_col = col[9:0];
         r.pixel_row = row[9:0];
         if (y >= 0) begin
            if (y == 0) deg = (x < 0) ? 180 : 0;
            else deg = bearing_deg(x, y);
            if (deg < NUM_BINS) begin
               r.range_value = int_sqrt(longint'(x * x + y * y));
               range_bins[deg] = r.range_value;
               r.bin_index = deg[8:0];
               r.bin_written = 1'b1;
            end
         end
      end
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   assign pending_count = expected_rsp.size();

   initial error_count = 0;

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         scale_ppm <= 10'd250;
         half_ext <= 15'd8192;
         img_w <= 11'd1000;
         img_h <= 11'd1000;
         for (int i = 0; i < NUM_BINS; i++) range_bins[i] = NO_READING;
         expected_rsp.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PPM:    scale_ppm <= csr_wdata[9:0];
               CSR_HALF:   half_ext <= csr_wdata;
               CSR_WIDTH:  img_w <= csr_wdata[10:0];
               CSR_HEIGHT: img_h <= csr_wdata[10:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_rsp.push_back(bin_point(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report("unexpected response", 0, 0);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.in_image !== e.in_image)
                  report("in_image", rsp_data.in_image, e.in_image);
               if (rsp_data.pixel_col !== e.pixel_col)
                  report("pixel_col", rsp_data.pixel_col, e.pixel_col);
               if (rsp_data.pixel_row !== e.pixel_row)
                  report("pixel_row", rsp_data.pixel_row, e.pixel_row);
               if (rsp_data.bin_index !== e.bin_index)
                  report("bin_index", rsp_data.bin_index, e.bin_index);
               if (rsp_data.bin_written !== e.bin_written)
                  report("bin_written", rsp_data.bin_written, e.bin_written);
               if (rsp_data.range_value !== e.range_value)
                  report("range_value", rsp_data.range_value, e.range_value);
            end
         end
      end
   end

endmodule

### verif/lidar_point_grid_and_range_binning_core_tb.sv
// Testbench top: clock, reset, request and register stimulus, response stalls and verdict.
module lidar_point_grid_and_range_binning_core_tb;
   import lpgrb_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [14:0] csr_wdata;
   int          error_count;
   int          pending_count;
   int          cycle_count;
   bit          calm_phase;
   bit          hold_rsp;

   lidar_point_grid_and_range_binning_core DUT (.*);

   lpgrb_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cycle_count = 0;
      calm_phase = 1'b0;
      hold_rsp = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   // response side: random stalls, none while calm, long hold when asked
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_rsp && (calm_phase || $urandom_range(99) >= 28);
   end

   task automatic send(input req_type rq);
      while (!calm_phase && $urandom_range(99) < 28) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [14:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic req_type point(input logic [15:0] x, input logic [15:0] y);
      req_type r;
      r = '0;
      r.point_x = x;
      r.point_y = y;
      r.bin_select = 9'($urandom);
      return r;
   endfunction

   function automatic req_type read_bin(input logic [8:0] b);
      req_type r;
      r = '0;
      r.point_x = 16'($urandom);
      r.point_y = 16'($urandom);
      r.opcode = 1'b1;
      r.bin_select = b;
      return r;
   endfunction

   // mostly points near the sensor, in the upper half plane, some wide noise and table reads
   function automatic req_type rand_req();
      int k;
      k = $urandom_range(99);
      if (k < 15) return read_bin((k < 3) ? 9'($urandom) : 9'($urandom_range(269)));
      if (k < 70) return point(16'($signed($urandom_range(16000)) - 8000),
                               16'($urandom_range(8000)));
      if (k < 80) return point(16'($urandom), 16'd0);
      return point(16'($urandom), 16'($urandom));
   endfunction

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) send(rand_req());
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed
      send(read_bin(9'd0));
      send(read_bin(9'd269));
      send(read_bin(9'd270));
      send(read_bin(9'd511));
      send(point(16'd0, 16'd0));
      send(point(16'd4096, 16'd0));
      send(point(-16'sd4096, 16'd0));
      send(point(16'd0, 16'd4096));
      send(point(16'd3000, 16'd3000));
      send(point(-16'sd3000, 16'd3000));
      send(point(-16'sd3000, 16'd10));
      send(point(16'd3000, -16'sd3000));
      send(point(16'h7FFF, 16'h7FFF));
      send(point(16'h8000, 16'h8000));
      send(point(16'h8000, 16'h7FFF));
      send(point(16'd8191, 16'd1));
      send(point(16'd1, 16'd8191));
      send(read_bin(9'd0));
      send(read_bin(9'd90));
      send(read_bin(9'd180));
      send(read_bin(9'd45));
      drain();
      write_reg(CSR_PPM, 15'd1023);
      write_reg(CSR_HALF, 15'd32767);
      write_reg(CSR_WIDTH, 15'h7FF);
      write_reg(CSR_HEIGHT, 15'd1024);
      send(point(16'h7FFF, 16'h7FFF));
      send(point(16'h8000, 16'd5));
      send(point(16'd0, 16'd0));
      drain();
      write_reg(CSR_PPM, 15'd1);
      write_reg(CSR_HALF, 15'd0);
      write_reg(CSR_WIDTH, 15'd0);
      write_reg(CSR_HEIGHT, 15'd1);
      send(point(16'd0, 16'd0));
      drain();
      write_reg(CSR_WIDTH, 15'd1);
      send(point(-16'sd5, 16'd0));
      send(point(-16'sd5000, -16'sd5000));
      drain();
      // random, with a stall-free stretch and a long response hold
      write_reg(CSR_PPM, 15'd250);
      write_reg(CSR_HALF, 15'd8192);
      write_reg(CSR_WIDTH, 15'd1000);
      write_reg(CSR_HEIGHT, 15'd1000);
      random_phase(200);
      calm_phase = 1'b1;
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         random_phase(100);
      join
      calm_phase = 1'b0;
      write_reg(CSR_PPM, 15'($urandom_range(1, 1023)));
      write_reg(CSR_HALF, 15'($urandom));
      write_reg(CSR_WIDTH, 15'($urandom_range(1, 2047)));
      write_reg(CSR_HEIGHT, 15'($urandom_range(1, 2047)));
      random_phase(150);
      write_reg(CSR_PPM, 15'd40);
      write_reg(CSR_HALF, 15'd30000);
      write_reg(CSR_WIDTH, 15'd512);
      write_reg(CSR_HEIGHT, 15'd700);
      random_phase(150);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### lidar_point_grid_and_range_binning_core.f
design/lpgrb_pkg.sv
design/lpgrb_cordic.sv
design/lidar_point_grid_and_range_binning_core.sv
verif/lpgrb_checker.sv
verif/lidar_point_grid_and_range_binning_core_tb.sv
